[hdl/jtdm_pkg.sv]
// ============================================================================
// jtdm_pkg: joystick tank-drive mixer shared definitions
// Event codes, button and axis assignments, widths, reset values and the
// stick state record passed between the event stage and the speed logic.
// ============================================================================
package jtdm_pkg;

    // Field widths
    localparam int AXIS_W    = 16;
    localparam int MASK_W    = 16;
    localparam int SPEED_W   = 10;
    localparam int AXIS_ID_W = 3;
    localparam int BTN_W     = 4;
    localparam int DZ_W      = 7;
    localparam int STEP_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Buttons that exist on the pad; higher indexes are ignored
    localparam int NUM_BUTTONS = 16;

    // Product width of -y * STICK_SCALE and the divide shift (32768)
    localparam int STICK_SCALE = 100;
    localparam int PROD_W      = 24;
    localparam int DIV_SHIFT   = 15;
    // Scaled stick value, -99..100
    localparam int RAW_W       = 8;

    // Event kinds
    typedef enum logic [1:0] {
        REQ_AXIS    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_QUIT    = 2'd3
    } t_req_type;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE  = 1'b0,
        CFG_TURBO_STEP = 1'b1
    } t_cfg_idx;

    // Axis and button assignments
    localparam logic [AXIS_ID_W-1:0] AXIS_LEFT_V  = 3'd1;
    localparam logic [AXIS_ID_W-1:0] AXIS_RIGHT_V = 3'd3;
    localparam int BTN_STOP_LEFT  = 0;
    localparam int BTN_STOP_RIGHT = 2;
    localparam int BTN_TURBO_A    = 5;
    localparam int BTN_TURBO_B    = 7;

    // Configuration reset values
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST  = 7'd50;
    localparam logic [STEP_W-1:0] TURBO_STEP_RST = 6'd20;

    // Stick and button state after an event
    typedef struct packed {
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] right_y;
        logic [MASK_W-1:0]        held;
        logic                     quit;
    } t_jtdm_state;

endpackage

[hdl/joystick_tank_drive_mixer.sv]
// ============================================================================
// joystick_tank_drive_mixer: joystick events to tank-drive commands
// The input register, the event/speed logic and the result register form a
// stall-together pipeline. Throughput: one event per cycle while
// m_axis_tready is high or the result register is empty.
// Reset: synchronous active-low; clears stick positions, buttons, quit flag,
// valids, and loads dead_zone = 50 and turbo_step = 20.
// ============================================================================
module joystick_tank_drive_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [jtdm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [jtdm_pkg::DZ_W-1:0]      i_cfg_wdata,
    // Event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] axis_index, [18:3] axis_value, [22:19] button_index, [23] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    // Drive command stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] right_speed, [19:10] left_speed, [20] quit_seen,
    // [36:21] buttons_held, [39:37] zero
    output logic [39:0] m_axis_tdata
);
    import jtdm_pkg::*;

    // Configuration registers
    logic [DZ_W-1:0]   r_dead_zone;
    logic [STEP_W-1:0] r_turbo_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= DEAD_ZONE_RST;
            r_turbo_step <= TURBO_STEP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_wdata;
                CFG_TURBO_STEP: r_turbo_step <= i_cfg_wdata[STEP_W-1:0];
                default: begin
                    r_dead_zone <= r_dead_zone;
                end
            endcase
        end
    end

    // Pipeline handshake: everything moves when the result slot is free
    logic r_in_vld;
    logic r_out_vld;
    logic advance;
    logic fire;
    logic in_acc;

    assign advance       = !r_out_vld || m_axis_tready;
    assign fire          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Input register
    t_req_type            r_type;
    logic [AXIS_ID_W-1:0] r_axis;
    logic [AXIS_W-1:0]    r_val;
    logic [BTN_W-1:0]     r_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_type <= t_req_type'(s_axis_tuser);
            r_axis <= s_axis_tdata[2:0];
            r_val  <= s_axis_tdata[18:3];
            r_btn  <= s_axis_tdata[22:19];
        end
    end

    // Event application
    t_jtdm_state st_next;

    jtdm_state u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_req_type     (r_type),
        .i_axis_index   (r_axis),
        .i_axis_value   (r_val),
        .i_button_index (r_btn),
        .o_next         (st_next)
    );

    // Per-side speeds
    logic signed [SPEED_W-1:0] spd_left;
    logic signed [SPEED_W-1:0] spd_right;

    jtdm_speed u_speed_left (
        .i_stick_y    (st_next.left_y),
        .i_dead_zone  (r_dead_zone),
        .i_turbo_step (r_turbo_step),
        .i_turbo_a    (st_next.held[BTN_TURBO_A]),
        .i_turbo_b    (st_next.held[BTN_TURBO_B]),
        .o_speed      (spd_left)
    );

    jtdm_speed u_speed_right (
        .i_stick_y    (st_next.right_y),
        .i_dead_zone  (r_dead_zone),
        .i_turbo_step (r_turbo_step),
        .i_turbo_a    (st_next.held[BTN_TURBO_A]),
        .i_turbo_b    (st_next.held[BTN_TURBO_B]),
        .o_speed      (spd_right)
    );

    // Stop buttons: left stop wins over right stop
    logic [SPEED_W-1:0] n_left;
    logic [SPEED_W-1:0] n_right;

    assign n_left  = st_next.held[BTN_STOP_LEFT] ? '0 : spd_left;
    assign n_right = (!st_next.held[BTN_STOP_LEFT] && st_next.held[BTN_STOP_RIGHT])
                   ? '0 : spd_right;

    // Result register
    logic [SPEED_W-1:0] r_left;
    logic [SPEED_W-1:0] r_right;
    logic               r_quit;
    logic [MASK_W-1:0]  r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_quit  <= st_next.quit;
            r_held  <= st_next.held;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_held, r_quit, r_left, r_right};

endmodule

[hdl/jtdm_state.sv]
// ============================================================================
// jtdm_state: event application and stick/button state
// Applies one joystick event to the stored stick positions, button mask and
// quit flag. The updated state is available combinationally in the same cycle.
// ============================================================================
module jtdm_state (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  jtdm_pkg::t_req_type           i_req_type,
    input  logic [jtdm_pkg::AXIS_ID_W-1:0] i_axis_index,
    input  logic [jtdm_pkg::AXIS_W-1:0]    i_axis_value,
    input  logic [jtdm_pkg::BTN_W-1:0]     i_button_index,
    output jtdm_pkg::t_jtdm_state         o_next
);
    import jtdm_pkg::*;

    t_jtdm_state r_st;
    t_jtdm_state n_st;
    logic        btn_ok;

    assign btn_ok = (int'(i_button_index) < NUM_BUTTONS);

    // Next state for the current event
    always_comb begin
        n_st = r_st;
        case (i_req_type)
            REQ_AXIS: begin
                if (i_axis_index == AXIS_LEFT_V) begin
                    n_st.left_y = $signed(i_axis_value);
                end else if (i_axis_index == AXIS_RIGHT_V) begin
                    n_st.right_y = $signed(i_axis_value);
                end
            end
            REQ_PRESS: begin
                if (btn_ok) begin
                    n_st.held[i_button_index] = 1'b1;
                end
            end
            REQ_RELEASE: begin
                if (btn_ok) begin
                    n_st.held[i_button_index] = 1'b0;
                end
            end
            REQ_QUIT: begin
                n_st.quit = 1'b1;
            end
            default: begin
                n_st = r_st;
            end
        endcase
    end

    // State register, updated once per processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    assign o_next = n_st;

endmodule

[hdl/jtdm_speed.sv]
// ============================================================================
// jtdm_speed: one side's drive speed from its stick position
// Scales the stick to -99..100 with truncation toward zero, applies the dead
// zone and doubling, then adds the turbo steps away from zero.
// ============================================================================
module jtdm_speed (
    input  logic signed [jtdm_pkg::AXIS_W-1:0]  i_stick_y,
    input  logic [jtdm_pkg::DZ_W-1:0]           i_dead_zone,
    input  logic [jtdm_pkg::STEP_W-1:0]         i_turbo_step,
    input  logic                                i_turbo_a,
    input  logic                                i_turbo_b,
    output logic signed [jtdm_pkg::SPEED_W-1:0] o_speed
);
    import jtdm_pkg::*;

    logic signed [PROD_W-1:0]  y_ext;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  adj;
    logic signed [RAW_W-1:0]   raw;
    logic signed [RAW_W-1:0]   raw_neg;
    logic [DZ_W-1:0]           mag;
    logic signed [SPEED_W-1:0] raw_ext;
    logic signed [SPEED_W-1:0] dz_ext;
    logic signed [SPEED_W-1:0] step_ext;
    logic signed [SPEED_W-1:0] shifted;
    logic signed [SPEED_W-1:0] base;
    logic signed [SPEED_W-1:0] turbo1;
    logic signed [SPEED_W-1:0] turbo2;

    // Scale: -y * 100, divide by 32768 rounding toward zero
    assign y_ext = PROD_W'(i_stick_y);
    assign prod  = PROD_W'(0) - (y_ext * PROD_W'(STICK_SCALE));
    assign adj   = prod[PROD_W-1] ? (prod + PROD_W'((1 << DIV_SHIFT) - 1)) : prod;
    assign raw   = adj[DIV_SHIFT+RAW_W-1:DIV_SHIFT];

    // Magnitude against the dead zone
    assign raw_neg = -raw;
    assign mag     = raw[RAW_W-1] ? raw_neg[DZ_W-1:0] : raw[DZ_W-1:0];

    assign raw_ext  = SPEED_W'(raw);
    assign dz_ext   = $signed({{(SPEED_W-DZ_W){1'b0}}, i_dead_zone});
    assign step_ext = $signed({{(SPEED_W-STEP_W){1'b0}}, i_turbo_step});

    // Pull toward zero by the dead zone, then double
    assign shifted = (raw > 0) ? (raw_ext - dz_ext) : (raw_ext + dz_ext);
    assign base    = (mag < i_dead_zone) ? '0 : (shifted <<< 1);

    // Turbo steps, zero counts as forward
    assign turbo1 = !i_turbo_a ? base
                  : (base[SPEED_W-1] ? base - step_ext : base + step_ext);
    assign turbo2 = !i_turbo_b ? turbo1
                  : (turbo1[SPEED_W-1] ? turbo1 - step_ext : turbo1 + step_ext);

    assign o_speed = turbo2;

endmodule

[verif/tb_top.sv]
// ============================================================================
// tb_top: joystick tank-drive mixer testbench
// Drives joystick events on the event stream, predicts the tank-drive
// command for each accepted event from a local model of the stick, button
// and quit state, and checks every command on the result stream in order.
// Runs a directed pass, then random passes under several register settings
// and several idle/stall patterns on both streams.
// ============================================================================
module tb_top;
    import jtdm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_RUN = 110;
    localparam int RANDOM_RUNS   = 8;
    localparam int MAX_SHOWN     = 10;
    localparam int DRAIN_CYCLES  = 8;

    // One joystick event
    typedef struct packed {
        t_req_type               kind;
        logic [BTN_W-1:0]        button;
        logic signed [AXIS_W-1:0] value;
        logic [AXIS_ID_W-1:0]    axis;
    } t_joy_event;

    // One drive command, packed as on the result bus (held in the top bits)
    typedef struct packed {
        logic [MASK_W-1:0]         held;
        logic                      quit;
        logic signed [SPEED_W-1:0] left_spd;
        logic signed [SPEED_W-1:0] right_spd;
    } t_drive_cmd;

    // ------------------------------------------------------------------------
    // Command tracker: mirrors the mixer state and queues expected commands
    // ------------------------------------------------------------------------
    class cmd_tracker;
        logic [DZ_W-1:0]          dead_zone;
        logic [STEP_W-1:0]        turbo_step;
        logic signed [AXIS_W-1:0] left_y;
        logic signed [AXIS_W-1:0] right_y;
        logic [MASK_W-1:0]        held;
        logic                     quit;
        t_drive_cmd               expected_cmds[$];
        int                       fails;

        function new();
            dead_zone  = DEAD_ZONE_RST;
            turbo_step = TURBO_STEP_RST;
            left_y     = '0;
            right_y    = '0;
            held       = '0;
            quit       = 1'b0;
            fails      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [DZ_W-1:0] val);
            if (idx == CFG_DEAD_ZONE) begin
                dead_zone = val;
            end else begin
                turbo_step = val[STEP_W-1:0];
            end
        endfunction

        // Scaled stick value with dead zone and doubling applied
        function int stick_speed(logic signed [AXIS_W-1:0] y);
            int yi;
            int v;
            int mag;
            int dz;
            yi  = y;
            v   = (-yi * STICK_SCALE) / (1 << DIV_SHIFT);
            dz  = dead_zone;
            mag = (v < 0) ? -v : v;
            if (mag < dz) return 0;
            if (v > 0) return (v - dz) * 2;
            return (v + dz) * 2;
        endfunction

        // Turbo pushes away from zero; zero counts as forward
        function int boost(int v);
            int s;
            s = turbo_step;
            return (v >= 0) ? v + s : v - s;
        endfunction

        function void apply_event(t_joy_event ev);
            int rs;
            int ls;
            t_drive_cmd cmd;
            case (ev.kind)
                REQ_AXIS: begin
                    if (ev.axis == AXIS_LEFT_V) left_y = ev.value;
                    else if (ev.axis == AXIS_RIGHT_V) right_y = ev.value;
                end
                REQ_PRESS: begin
                    if (ev.button < NUM_BUTTONS) held[ev.button] = 1'b1;
                end
                REQ_RELEASE: begin
                    if (ev.button < NUM_BUTTONS) held[ev.button] = 1'b0;
                end
                default: begin
                    quit = 1'b1;
                end
            endcase
            rs = stick_speed(right_y);
            ls = stick_speed(left_y);
            if (held[BTN_TURBO_A]) begin
                rs = boost(rs);
                ls = boost(ls);
            end
            if (held[BTN_TURBO_B]) begin
                rs = boost(rs);
                ls = boost(ls);
            end
            // stop-left wins over stop-right
            if (held[BTN_STOP_LEFT]) ls = 0;
            else if (held[BTN_STOP_RIGHT]) rs = 0;
            cmd.right_spd = SPEED_W'(rs);
            cmd.left_spd  = SPEED_W'(ls);
            cmd.quit      = quit;
            cmd.held      = held;
            expected_cmds.push_back(cmd);
        endfunction

        function void flag(string what);
            fails++;
            if (fails <= MAX_SHOWN) $display("ERROR: %s", what);
        endfunction

        function void check_cmd(logic [39:0] data);
            t_drive_cmd got;
            t_drive_cmd exp_cmd;
            got = data[$bits(t_drive_cmd)-1:0];
            if (expected_cmds.size() == 0) begin
                flag($sformatf("unexpected command %h", data));
                return;
            end
            exp_cmd = expected_cmds.pop_front();
            if (got.right_spd !== exp_cmd.right_spd)
                flag($sformatf("right_speed exp %0d got %0d",
                               exp_cmd.right_spd, got.right_spd));
            if (got.left_spd !== exp_cmd.left_spd)
                flag($sformatf("left_speed exp %0d got %0d",
                               exp_cmd.left_spd, got.left_spd));
            if (got.quit !== exp_cmd.quit)
                flag($sformatf("quit_seen exp %0b got %0b", exp_cmd.quit, got.quit));
            if (got.held !== exp_cmd.held)
                flag($sformatf("buttons_held exp %h got %h", exp_cmd.held, got.held));
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [DZ_W-1:0]      i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;

    int gap_pct   = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    cmd_tracker tracker = new();
    t_joy_event seen_ev;

    joystick_tank_drive_mixer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Receiver backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Monitor: note accepted events first, then check accepted commands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen_ev.kind   = t_req_type'(s_axis_tuser);
                seen_ev.axis   = s_axis_tdata[2:0];
                seen_ev.value  = s_axis_tdata[18:3];
                seen_ev.button = s_axis_tdata[22:19];
                tracker.apply_event(seen_ev);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.check_cmd(m_axis_tdata);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    function automatic t_joy_event mk_event(t_req_type kind, int axis, int value,
                                            int button);
        t_joy_event ev;
        ev.kind   = kind;
        ev.axis   = AXIS_ID_W'(axis);
        ev.value  = AXIS_W'(value);
        ev.button = BTN_W'(button);
        return ev;
    endfunction

    task automatic send_event(t_joy_event ev);
        while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ev.button, ev.value, ev.axis};
        s_axis_tuser  <= ev.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Both registers, back to back; block must be idle
    task automatic program_regs(logic [DZ_W-1:0] dz, logic [STEP_W-1:0] step);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_DEAD_ZONE;
        i_cfg_wdata <= dz;
        tracker.write_reg(CFG_DEAD_ZONE, dz);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_TURBO_STEP;
        i_cfg_wdata <= {1'b0, step};
        tracker.write_reg(CFG_TURBO_STEP, {1'b0, step});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // Stick values weighted toward extremes and the zero region
    function automatic int pick_stick();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(4))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1: return $urandom_range(800) - 400;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // Special buttons (stop and turbo) most of the time
    function automatic int pick_button();
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(3))
                0: return BTN_STOP_LEFT;
                1: return BTN_STOP_RIGHT;
                2: return BTN_TURBO_A;
                default: return BTN_TURBO_B;
            endcase
        end
        return $urandom_range(NUM_BUTTONS - 1);
    endfunction

    function automatic t_joy_event random_event();
        int roll;
        int axis;
        roll = $urandom_range(99);
        if (roll < 45) begin
            if ($urandom_range(99) < 80)
                axis = $urandom_range(1) ? AXIS_RIGHT_V : AXIS_LEFT_V;
            else
                axis = $urandom_range(7);
            return mk_event(REQ_AXIS, axis, pick_stick(), $urandom_range(15));
        end
        if (roll < 71)
            return mk_event(REQ_PRESS, $urandom_range(7), $urandom(), pick_button());
        if (roll < 97)
            return mk_event(REQ_RELEASE, $urandom_range(7), $urandom(), pick_button());
        return mk_event(REQ_QUIT, $urandom_range(7), $urandom(), $urandom_range(15));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_joy_event directed[$];
        int dz;
        int step;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed pass at reset register values, no idling
        directed.push_back(mk_event(REQ_AXIS, AXIS_LEFT_V, -32768, 0));
        directed.push_back(mk_event(REQ_AXIS, AXIS_RIGHT_V, 32767, 15));
        // other axes leave state alone
        directed.push_back(mk_event(REQ_AXIS, 0, 12345, 0));
        directed.push_back(mk_event(REQ_AXIS, 7, -1, 0));
        directed.push_back(mk_event(REQ_AXIS, 5, -21846, 0));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, BTN_TURBO_A));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, BTN_TURBO_B));
        // zero speed picks up forward turbo
        directed.push_back(mk_event(REQ_AXIS, AXIS_LEFT_V, 0, 0));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, BTN_STOP_LEFT));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, BTN_STOP_RIGHT));
        directed.push_back(mk_event(REQ_RELEASE, 0, 0, BTN_STOP_LEFT));
        directed.push_back(mk_event(REQ_RELEASE, 0, 0, BTN_STOP_RIGHT));
        directed.push_back(mk_event(REQ_RELEASE, 0, 0, BTN_TURBO_A));
        directed.push_back(mk_event(REQ_RELEASE, 0, 0, BTN_TURBO_B));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, 15));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, 15));
        directed.push_back(mk_event(REQ_RELEASE, 7, -32768, 15));
        // release of a button that is not held
        directed.push_back(mk_event(REQ_RELEASE, 0, 0, 9));
        // right stick right at and just below the dead zone
        directed.push_back(mk_event(REQ_AXIS, AXIS_RIGHT_V, -16384, 0));
        directed.push_back(mk_event(REQ_AXIS, AXIS_RIGHT_V, -16057, 0));
        directed.push_back(mk_event(REQ_QUIT, 0, 0, 0));
        // events after quit still apply
        directed.push_back(mk_event(REQ_AXIS, AXIS_LEFT_V, 32767, 0));
        directed.push_back(mk_event(REQ_PRESS, 0, 0, BTN_TURBO_A));
        directed.push_back(mk_event(REQ_QUIT, 0, 0, 0));
        foreach (directed[i]) send_event(directed[i]);
        wait_drained();

        // Random passes, register setting and idle pattern change per pass
        for (int run = 1; run <= RANDOM_RUNS; run++) begin
            case (run)
                1: begin dz = 0;   step = 0;  end
                2: begin dz = 100; step = 50; end
                3: begin dz = 1;   step = 50; end
                4: begin dz = 100; step = 0;  end
                default: begin
                    dz   = $urandom_range(100, 1);
                    step = $urandom_range(50);
                end
            endcase
            program_regs(DZ_W'(dz), STEP_W'(step));
            case (run % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 52; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 52; end
                default: begin gap_pct = 34; stall_pct = 34; end
            endcase
            for (int n = 0; n < ITEMS_PER_RUN; n++) send_event(random_event());
            wait_drained();
            gap_pct   = 0;
            stall_pct = 0;
        end

        // Tail: catch any stray command
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if ((tracker.fails == 0) && (tracker.pending() == 0)) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/jtdm_pkg.sv
hdl/jtdm_state.sv
hdl/jtdm_speed.sv
hdl/joystick_tank_drive_mixer.sv
verif/tb_top.sv
